/* sv/nmtbn_pkg.sv */
// Package: shared types and constants for the tangent-space normal mapping pipeline.
package nmtbn_pkg;

	localparam int unsigned ONE_Q15 = 32768;
	localparam int unsigned SQRT_STEPS = 32;   // result bits of the 64-bit root
	localparam int unsigned DIV_BITS = 17;     // quotient bits (up to 2*ONE/.. ~ 2^16+)

	// Normaliser request: three signed magnitudes of at most 2^31
	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} vec33_t;

	// Normalised unit vector, 1.0 = 32768
	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
	} unit_t;

endpackage

/* sv/nmtbn_if.sv */
// Interface: valid/ready channel carrying a payload of parameterised type.
interface nmtbn_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/nmtbn_norm.sv */
// Pipelined vector normaliser: shift up, sum of squares, bit-serial root, dividers.
module nmtbn_norm
	import nmtbn_pkg::*;
#(
	parameter int unsigned TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  vec33_t           in_vec,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output unit_t            out_vec,
	output logic             out_zero,
	output logic [TAG_W-1:0] out_tag
);

	// total stages: 1 shift, 1 square, 1 sum, SQRT_STEPS root, DIV_BITS divide, 1 sign
	localparam int unsigned NST = 3 + SQRT_STEPS + DIV_BITS + 1;

	logic [NST-1:0] vld_q;

	// stage 1: magnitudes and left shift so the largest reaches 2^30
	logic [31:0] mag_c [3];
	logic [31:0] mx_c;
	logic [5:0]  sh_c;
	logic [2:0]  neg_c;

	always_comb begin
		mag_c[0] = in_vec.x[32] ? 32'(-in_vec.x) : in_vec.x[31:0];
		mag_c[1] = in_vec.y[32] ? 32'(-in_vec.y) : in_vec.y[31:0];
		mag_c[2] = in_vec.z[32] ? 32'(-in_vec.z) : in_vec.z[31:0];
		neg_c = {in_vec.z[32], in_vec.y[32], in_vec.x[32]};
		mx_c = mag_c[0] | mag_c[1] | mag_c[2];
		// highest set bit wins; bit 31 or 30 needs no shift
		sh_c = '0;
		for (int i = 0; i <= 30; i++) begin
			if (mx_c[i])
				sh_c = 6'(30 - i);
		end
		if (mx_c[31])
			sh_c = '0;
	end

	logic [31:0]      m_s1 [3];
	logic [2:0]       neg_s1;
	logic             zero_s1;
	logic [TAG_W-1:0] tag_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) m_s1[i] <= mag_c[i] << sh_c;
			neg_s1 <= neg_c;
			zero_s1 <= (mx_c == '0);
			tag_s1 <= in_tag;
		end
	end

	// stage 2: squares
	logic [63:0]      sq_s2 [3];
	logic [31:0]      m_s2 [3];
	logic [2:0]       neg_s2;
	logic             zero_s2;
	logic [TAG_W-1:0] tag_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= m_s1[i] * m_s1[i];
				m_s2[i] <= m_s1[i];
			end
			neg_s2 <= neg_s1;
			zero_s2 <= zero_s1;
			tag_s2 <= tag_s1;
		end
	end

	// stage 3: sum of squares (< 2^64 since each term <= 2^62)
	logic [63:0]      sum_s3;
	logic [31:0]      m_s3 [3];
	logic [2:0]       neg_s3;
	logic             zero_s3;
	logic [TAG_W-1:0] tag_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			m_s3 <= m_s2;
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
			tag_s3 <= tag_s2;
		end
	end

	// root stages: one result bit per stage, restoring method
	logic [63:0]      rem_r [SQRT_STEPS+1];
	logic [31:0]      root_r [SQRT_STEPS+1];
	logic [31:0]      m_r [SQRT_STEPS+1][3];
	logic [2:0]       neg_r [SQRT_STEPS+1];
	logic             zero_r [SQRT_STEPS+1];
	logic [TAG_W-1:0] tag_r [SQRT_STEPS+1];

	assign rem_r[0] = sum_s3;
	assign root_r[0] = '0;
	assign m_r[0] = m_s3;
	assign neg_r[0] = neg_s3;
	assign zero_r[0] = zero_s3;
	assign tag_r[0] = tag_s3;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
		localparam int unsigned B = SQRT_STEPS - 1 - k;
		logic [31:0] cand_c;
		assign cand_c = root_r[k] | (32'd1 << B);
		// (root|bit)^2 <= x, tested on the remainder
		logic [65:0] sub_c;
		always_comb sub_c = {2'b0, rem_r[k]} - ((66'(root_r[k]) << (B + 1))
			+ (66'd1 << (2 * B)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!sub_c[65]) begin
					rem_r[k+1] <= sub_c[63:0];
					root_r[k+1] <= cand_c;
				end else begin
					rem_r[k+1] <= rem_r[k];
					root_r[k+1] <= root_r[k];
				end
				m_r[k+1] <= m_r[k];
				neg_r[k+1] <= neg_r[k];
				zero_r[k+1] <= zero_r[k];
				tag_r[k+1] <= tag_r[k];
			end
		end
	end

	// divide stages: q = floor((mag*2^16 + L) / (2L)), three lanes, one bit each
	localparam int unsigned NW = 50;
	logic [NW-1:0]    num_d [DIV_BITS+1][3];
	logic [DIV_BITS-1:0] q_d [DIV_BITS+1][3];
	logic [32:0]      den_d [DIV_BITS+1];
	logic [2:0]       neg_d [DIV_BITS+1];
	logic             zero_d [DIV_BITS+1];
	logic [TAG_W-1:0] tag_d [DIV_BITS+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_d[0][i] = (NW'(m_r[SQRT_STEPS][i]) << 16) + NW'(root_r[SQRT_STEPS]);
			q_d[0][i] = '0;
		end
	end
	assign den_d[0] = {root_r[SQRT_STEPS], 1'b0};
	assign neg_d[0] = neg_r[SQRT_STEPS];
	assign zero_d[0] = zero_r[SQRT_STEPS];
	assign tag_d[0] = tag_r[SQRT_STEPS];

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		localparam int unsigned B = DIV_BITS - 1 - k;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [NW:0] sub_c;
			assign sub_c = {1'b0, num_d[k][i]} - ((NW+1)'(den_d[k]) << B);
			always_ff @(posedge clk) begin
				if (en) begin
					if (!sub_c[NW]) begin
						num_d[k+1][i] <= sub_c[NW-1:0];
						q_d[k+1][i] <= q_d[k][i] | (DIV_BITS'(1) << B);
					end else begin
						num_d[k+1][i] <= num_d[k][i];
						q_d[k+1][i] <= q_d[k][i];
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_d[k+1] <= den_d[k];
				neg_d[k+1] <= neg_d[k];
				zero_d[k+1] <= zero_d[k];
				tag_d[k+1] <= tag_d[k];
			end
		end
	end

	// final stage: clamp and sign
	function automatic logic signed [17:0] fin(input logic [DIV_BITS-1:0] q, input logic n,
		input logic z);
		logic [17:0] c;
		c = (q > DIV_BITS'(ONE_Q15)) ? 18'(ONE_Q15) : 18'(q);
		if (z) return '0;
		return n ? -$signed(c) : $signed(c);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec.x <= fin(q_d[DIV_BITS][0], neg_d[DIV_BITS][0], zero_d[DIV_BITS]);
			out_vec.y <= fin(q_d[DIV_BITS][1], neg_d[DIV_BITS][1], zero_d[DIV_BITS]);
			out_vec.z <= fin(q_d[DIV_BITS][2], neg_d[DIV_BITS][2], zero_d[DIV_BITS]);
			out_zero <= zero_d[DIV_BITS];
			out_tag <= tag_d[DIV_BITS];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[NST-1];

	logic unused_rem;
	assign unused_rem = ^rem_r[SQRT_STEPS] ^ ^num_d[DIV_BITS][0] ^ ^num_d[DIV_BITS][1]
		^ ^num_d[DIV_BITS][2] ^ ^den_d[DIV_BITS];

	// zero flag only on an all-zero request
	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_zero) |-> (out_vec.x == 0 && out_vec.y == 0 && out_vec.z == 0))
		else $error("zero vector gave nonzero output");
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_vec.x <= 18'sd32768 && out_vec.x >= -18'sd32768))
		else $error("component out of unit range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during stall");

endmodule

/* sv/normal_map_tbn_transform.sv */
// Pipeline: two 53-stage normaliser passes in series, plus two frame stages before and
// two after the bitangent pass, from input beat to result.
// Throughput: one beat per cycle; the whole pipeline advances whenever the output stage is free.
// A stall at the output freezes every stage; nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits at once; payload registers are not reset.
module normal_map_tbn_transform
	import nmtbn_pkg::*;
#(
	parameter int unsigned COMPONENT_WIDTH = 16,
	parameter int unsigned TEXEL_WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	nmtbn_if.sink   in_ch,
	nmtbn_if.source out_ch
);

	localparam int unsigned CW = COMPONENT_WIDTH;
	localparam int unsigned TW = TEXEL_WIDTH;
	localparam int unsigned TMAX = (1 << TW) - 1;

	// payload field slices (struct from the interface)
	logic signed [CW-1:0] nx, ny, nz;
	logic [TW-1:0]        tr, tg, tb;
	assign nx = in_ch.data.normal_x;
	assign ny = in_ch.data.normal_y;
	assign nz = in_ch.data.normal_z;
	assign tr = in_ch.data.texel_red;
	assign tg = in_ch.data.texel_green;
	assign tb = in_ch.data.texel_blue;

	// global enable: advance when the output register can take a beat
	logic en;
	logic out_vld_q;
	assign en = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// first pass tags carry raw normal and texel vector data
	localparam int unsigned TAG1 = 3 * CW + 3 * (TW + 2);
	typedef struct packed {
		logic signed [CW-1:0] nx, ny, nz;
		logic signed [TW+1:0] ex, ey, ez;
	} tag1_t;

	tag1_t tag_in, tag_n1, tag_e1_unused;
	vec33_t n_req, e_req, t_req;

	always_comb begin
		tag_in.nx = nx;
		tag_in.ny = ny;
		tag_in.nz = nz;
		tag_in.ex = $signed(({2'b0, tr} << 1)) - $signed((TW+2)'(TMAX));
		tag_in.ey = $signed(({2'b0, tg} << 1)) - $signed((TW+2)'(TMAX));
		tag_in.ez = $signed(({2'b0, tb} << 1)) - $signed((TW+2)'(TMAX));
		n_req.x = 33'(nx);
		n_req.y = 33'(ny);
		n_req.z = 33'(nz);
		e_req.x = 33'(tag_in.ex);
		e_req.y = 33'(tag_in.ey);
		e_req.z = 33'(tag_in.ez);
		// tangent N x +Y = (-nz, 0, nx)
		t_req.x = -33'(nz);
		t_req.y = '0;
		t_req.z = 33'(nx);
	end

	// pass A: normal, texel and tangent in parallel
	logic  va_n, va_e, va_t;
	unit_t un, ue, ut;
	logic  zn, ze, zt;
	logic [TAG1-1:0] tag_e_raw, tag_t_raw;

	nmtbn_norm #(.TAG_W(TAG1)) u_norm_n (
		.clk, .arst_n, .en, .in_valid(in_ch.valid && en), .in_vec(n_req), .in_tag(tag_in),
		.out_valid(va_n), .out_vec(un), .out_zero(zn), .out_tag(tag_n1)
	);
	nmtbn_norm #(.TAG_W(TAG1)) u_norm_e (
		.clk, .arst_n, .en, .in_valid(in_ch.valid && en), .in_vec(e_req), .in_tag(tag_in),
		.out_valid(va_e), .out_vec(ue), .out_zero(ze), .out_tag(tag_e_raw)
	);
	nmtbn_norm #(.TAG_W(TAG1)) u_norm_t (
		.clk, .arst_n, .en, .in_valid(in_ch.valid && en), .in_vec(t_req), .in_tag(tag_in),
		.out_valid(va_t), .out_vec(ut), .out_zero(zt), .out_tag(tag_t_raw)
	);
	assign tag_e1_unused = tag1_t'(tag_e_raw ^ tag_t_raw);

	// stage P1: pick the tangent (fallback N x +Z) and register the frame
	unit_t n_p1, e_p1, t_p1;
	logic  deg_p1, v_p1;
	always_ff @(posedge clk) begin
		if (en) begin
			n_p1 <= un;
			e_p1 <= ue;
			deg_p1 <= zn || ze;
			if (zt) begin
				t_p1.x <= un.y;
				t_p1.y <= -un.x;
				t_p1.z <= '0;
			end else begin
				t_p1 <= ut;
			end
		end
	end

	// stage P2: products for bitangent
	logic signed [35:0] p_s2 [6];
	unit_t n_p2, e_p2, t_p2;
	logic  deg_p2, v_p2;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= n_p1.y * t_p1.z;
			p_s2[1] <= n_p1.z * t_p1.y;
			p_s2[2] <= n_p1.z * t_p1.x;
			p_s2[3] <= n_p1.x * t_p1.z;
			p_s2[4] <= n_p1.x * t_p1.y;
			p_s2[5] <= n_p1.y * t_p1.x;
			n_p2 <= n_p1;
			e_p2 <= e_p1;
			t_p2 <= t_p1;
			deg_p2 <= deg_p1;
		end
	end

	// pass B: normalise the bitangent
	typedef struct packed {
		unit_t n, e, t;
		logic  deg;
	} tag2_t;
	localparam int unsigned TAG2 = $bits(tag2_t);
	tag2_t tag2_in, tag2_out;
	vec33_t b_req;
	always_comb begin
		b_req.x = 33'(p_s2[0] - p_s2[1]);
		b_req.y = 33'(p_s2[2] - p_s2[3]);
		b_req.z = 33'(p_s2[4] - p_s2[5]);
		tag2_in.n = n_p2;
		tag2_in.e = e_p2;
		tag2_in.t = t_p2;
		tag2_in.deg = deg_p2;
	end

	logic  vb, zb;
	unit_t ub;
	logic [TAG2-1:0] tag2_raw;
	nmtbn_norm #(.TAG_W(TAG2)) u_norm_b (
		.clk, .arst_n, .en, .in_valid(v_p2), .in_vec(b_req), .in_tag(tag2_in),
		.out_valid(vb), .out_vec(ub), .out_zero(zb), .out_tag(tag2_raw)
	);
	assign tag2_out = tag2_t'(tag2_raw);

	// stage M: frame times texel, nine products
	logic signed [35:0] m_s [3][3];
	logic deg_m, v_m;
	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0][0] <= tag2_out.t.x * tag2_out.e.x;
			m_s[0][1] <= ub.x * tag2_out.e.y;
			m_s[0][2] <= tag2_out.n.x * tag2_out.e.z;
			m_s[1][0] <= tag2_out.t.y * tag2_out.e.x;
			m_s[1][1] <= ub.y * tag2_out.e.y;
			m_s[1][2] <= tag2_out.n.y * tag2_out.e.z;
			m_s[2][0] <= tag2_out.t.z * tag2_out.e.x;
			m_s[2][1] <= ub.z * tag2_out.e.y;
			m_s[2][2] <= tag2_out.n.z * tag2_out.e.z;
			deg_m <= tag2_out.deg;
		end
	end

	// output stage: sum, round half up, saturate
	function automatic logic signed [15:0] rnd(input logic signed [37:0] s);
		logic signed [37:0] r;
		r = (s + 38'sd16384) >>> 15;
		if (r > 38'sd32767) return 16'sd32767;
		if (r < -38'sd32768) return -16'sd32768;
		return r[15:0];
	endfunction

	logic signed [37:0] sum_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			sum_c[i] = 38'(m_s[i][0]) + 38'(m_s[i][1]) + 38'(m_s[i][2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.bumped_x <= deg_m ? '0 : rnd(sum_c[0]);
			out_ch.data.bumped_y <= deg_m ? '0 : rnd(sum_c[1]);
			out_ch.data.bumped_z <= deg_m ? '0 : rnd(sum_c[2]);
			out_ch.data.degenerate <= deg_m;
		end
	end

	// valid chain for the glue stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_m <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_p1 <= va_n;
			v_p2 <= v_p1;
			v_m <= vb;
			out_vld_q <= v_m;
		end
	end
	assign out_ch.valid = out_vld_q;

	logic unused_top;
	assign unused_top = va_e ^ va_t ^ zb ^ (^tag_n1) ^ (^tag_e1_unused);

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		va_n == va_e && va_n == va_t)
		else $error("parallel normalisers out of step");
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.degenerate) |-> (out_ch.data.bumped_x == 0
		&& out_ch.data.bumped_y == 0 && out_ch.data.bumped_z == 0))
		else $error("degenerate result not zeroed");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("result dropped under stall");

endmodule
